// ===== sv/double_ended_queue_with_half_rotate_assert.svh =====
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shorthand for the concurrent checks in the deque RTL. Each use expects clk
// and rst to be in scope.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_HALF_ROTATE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_HALF_ROTATE_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define DEQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Command and status codes, data width and the store control group.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROTATE     = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Store strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== sv/deq_if.sv =====
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready channels for command requests and result requests.
// ----------------------------------------------------------------------------
interface deq_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface deq_res_if #(
  parameter int CNT_W = 9
);
  logic               valid;
  logic               ready;
  logic signed [31:0] pop_value;
  logic [1:0]         status;
  logic [CNT_W-1:0]   entry_count;

  modport source (output valid, output pop_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input entry_count,
                  output ready);
endinterface

// ===== sv/deq_store.sv =====
// ----------------------------------------------------------------------------
// Deque ring store
// One write port and one registered read port over DEPTH entries.
// ----------------------------------------------------------------------------
module deq_store #(
  parameter int DEPTH = 256
) (
  input  logic                          clk,
  input  deq_pkg::mem_ctl_t             ctl,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [deq_pkg::DATA_W-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [deq_pkg::DATA_W-1:0]    rd_data
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write the pushed value, register the popped entry
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

// ===== sv/double_ended_queue_with_half_rotate.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue with half rotate
// Bounded deque over a ring store with a front pointer and an entry count.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    command, push_value
//  res      out  valid/ready    pop_value, status, entry_count
//
// One command is taken per cycle while cmd.ready is high; its result is presented the cycle after
// acceptance, with the popped value read from the store's registered port.
// Pointers and count update at acceptance, so back-to-back commands see them.
// Reset clears the pointer, count and result valid; store contents stay
// undefined until pushed, so there is no clearing pass.
// cmd.ready drops only while a result is held and res.ready is low.
//
`include "double_ended_queue_with_half_rotate_assert.svh"

module double_ended_queue_with_half_rotate #(
  parameter int DEPTH = 256
) (
  input  logic  clk,
  input  logic  rst,
  deq_cmd_if.sink   cmd,
  deq_res_if.source res
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] WRAP_C  = SUM_W'(DEPTH);

  logic [IDX_W-1:0]  front;
  logic [IDX_W-1:0]  front_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              res_valid;
  logic [STAT_W-1:0] res_status;
  logic [STAT_W-1:0] status_next;
  logic              pop_ok;
  logic              pop_ok_next;
  logic              accept;
  mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rd_data;

  // Fold a sum below twice the depth back into the ring
  function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    r = (v >= WRAP_C) ? (v - WRAP_C) : v;
    return r[IDX_W-1:0];
  endfunction

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !res_valid || res.ready;

  // Decode the command into pointer updates and store strobes
  always_comb begin
    front_next    = front;
    count_next    = count;
    status_next   = ST_OK;
    pop_ok_next   = 1'b0;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    waddr         = front;
    raddr         = front;
    case (cmd.command)
      CMD_PUSH_FRONT: begin
        if (count == DEPTH_C) begin
          status_next = ST_FULL;
        end else begin
          front_next    = (front == '0) ? LAST_C : front - 1'b1;
          waddr         = front_next;
          mem_ctl.wr_en = accept;
          count_next    = count + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (count == DEPTH_C) begin
          status_next = ST_FULL;
        end else begin
          waddr         = wrap(SUM_W'(front) + SUM_W'(count));
          mem_ctl.wr_en = accept;
          count_next    = count + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          raddr         = front;
          mem_ctl.rd_en = accept;
          pop_ok_next   = 1'b1;
          front_next    = (front == LAST_C) ? '0 : front + 1'b1;
          count_next    = count - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          raddr         = wrap(SUM_W'(front) + SUM_W'(count) - 1'b1);
          mem_ctl.rd_en = accept;
          pop_ok_next   = 1'b1;
          count_next    = count - 1'b1;
        end
      end
      CMD_ROTATE: begin
        if (count >= CNT_W'(2)) begin
          front_next = wrap(SUM_W'(front) + SUM_W'(count >> 1));
        end
      end
      default: begin
      end
    endcase
  end

  deq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .waddr   (waddr),
    .wdata   (DATA_W'(cmd.push_value)),
    .raddr   (raddr),
    .rd_data (rd_data)
  );

  // Advance pointers and hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        front <= front_next;
        count <= count_next;
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status_next;
      pop_ok     <= pop_ok_next;
    end
  end

  assign res.valid       = res_valid;
  assign res.status      = res_status;
  assign res.entry_count = count;
  assign res.pop_value   = pop_ok ? rd_data : '0;

  `DEQ_ASSERT_NEXT(a_result_follows, accept, res.valid,
                   "accepted command gave no result")
  `DEQ_ASSERT_NEXT(a_idle_holds, !accept, $stable(count) && $stable(front),
                   "pointer state moved without a command")
  `DEQ_ASSERT_NEXT(a_pop_drops_one,
                   accept && count != '0 &&
                   (cmd.command == CMD_POP_FRONT || cmd.command == CMD_POP_BACK),
                   pop_ok && count == $past(count) - 1'b1,
                   "pop did not remove exactly one entry")
  `DEQ_ASSERT_SAME(a_full_count, res.valid && res.status == ST_FULL,
                   res.entry_count == DEPTH_C,
                   "full status reported without a full queue")

endmodule

// ===== tb/tb_double_ended_queue_with_half_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with half rotate testbench
// Drives command requests from a directed table and then from biased random
// episodes, under changing sender and receiver idling. A shadow deque works
// out each result, and every result request is compared field by field.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_with_half_rotate;
  import deq_pkg::*;

  localparam int DEPTH       = 256;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_STALL  = 200;
  localparam int TAIL_CYCLES = 8;

  // Command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [STAT_W-1:0]        status;
    logic [8:0]               entry_count;
  } deq_result_t;

  typedef struct {
    logic [CMD_W-1:0]  op;
    logic [DATA_W-1:0] val;
    bit                pinned;
    deq_result_t       want;
  } cmd_row_t;

  typedef enum {MIX_OPS, FILL_OPS, DRAIN_OPS} op_bias_t;

  localparam deq_result_t NO_RESULT = '0;

  logic clk;
  logic rst;

  deq_cmd_if               cmd_ch ();
  deq_res_if #(.CNT_W(9))  res_ch ();

  double_ended_queue_with_half_rotate #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // Shadow deque state
  logic [DATA_W-1:0] shadow_ring [DEPTH];
  logic [7:0]        shadow_front;
  logic [8:0]        shadow_count;

  deq_result_t expected_results [$];
  cmd_row_t    offered_requests [$];
  cmd_row_t    directed_rows [24];

  int error_total;
  int send_idle_pct;
  int recv_idle_pct;
  int plan_level;
  bit hold_off_req;
  int hold_off_left;
  int quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the result of one command and advance the shadow deque
  function automatic deq_result_t model_command(logic [CMD_W-1:0] op,
                                                logic [DATA_W-1:0] val);
    deq_result_t r;
    logic [7:0]  slot;
    r = '0;
    r.status = ST_OK;
    case (op)
      CMD_PUSH_FRONT: begin
        if (shadow_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_front = shadow_front - 8'd1;
          shadow_ring[shadow_front] = val;
          shadow_count = shadow_count + 9'd1;
        end
      end
      CMD_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = shadow_front + shadow_count[7:0];
          shadow_ring[slot] = val;
          shadow_count = shadow_count + 9'd1;
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.pop_value = shadow_ring[shadow_front];
          shadow_front = shadow_front + 8'd1;
          shadow_count = shadow_count - 9'd1;
        end
      end
      CMD_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = shadow_front + shadow_count[7:0] - 8'd1;
          r.pop_value = shadow_ring[slot];
          shadow_count = shadow_count - 9'd1;
        end
      end
      CMD_ROTATE: begin
        if (shadow_count >= 2) shadow_front = shadow_front + 8'(shadow_count >> 1);
      end
      default: ;
    endcase
    r.entry_count = shadow_count;
    return r;
  endfunction

  // Values lean on the extremes now and then
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_spare();
    case ($urandom_range(2))
      0:       return CMD_SPARE_A;
      1:       return CMD_SPARE_B;
      default: return CMD_SPARE_C;
    endcase
  endfunction

  // Choose a command, weighted towards filling, draining or a balanced mix
  function automatic logic [CMD_W-1:0] pick_op(op_bias_t bias);
    int r;
    r = $urandom_range(99);
    case (bias)
      FILL_OPS: begin
        if (r < 46) return CMD_PUSH_FRONT;
        if (r < 92) return CMD_PUSH_BACK;
        if (r < 96) return CMD_ROTATE;
        return (r < 98) ? CMD_POP_FRONT : CMD_POP_BACK;
      end
      DRAIN_OPS: begin
        if (r < 46) return CMD_POP_FRONT;
        if (r < 92) return CMD_POP_BACK;
        if (r < 96) return CMD_ROTATE;
        return (r < 98) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      end
      default: begin
        if (r < 22) return CMD_PUSH_FRONT;
        if (r < 44) return CMD_PUSH_BACK;
        if (r < 64) return CMD_POP_FRONT;
        if (r < 84) return CMD_POP_BACK;
        if (r < 96) return CMD_ROTATE;
        return pick_spare();
      end
    endcase
  endfunction

  // Offer one command request and hold it until taken; call at a falling edge
  task automatic send_request(logic [CMD_W-1:0] op, logic [DATA_W-1:0] val,
                              bit pinned, deq_result_t want);
    cmd_row_t row;
    row.op     = op;
    row.val    = val;
    row.pinned = pinned;
    row.want   = want;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    offered_requests.push_back(row);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= op;
    cmd_ch.push_value <= val;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
    // Track the fill level for steering the episodes
    if ((op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) && plan_level < DEPTH)
      plan_level++;
    else if ((op == CMD_POP_FRONT || op == CMD_POP_BACK) && plan_level > 0)
      plan_level--;
  endtask

  // Hold off the sender until every result request has come back
  task automatic wait_for_results();
    cmd_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic run_ops(op_bias_t bias, int n_items, int hold_at);
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      send_request(pick_op(bias), pick_value(), 1'b0, NO_RESULT);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    res_ch.ready  = 1'b0;
    hold_off_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req  = 1'b0;
        hold_off_left = LONG_STALL - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Predict on each accepted command, check each accepted result
  always @(posedge clk) begin : result_check
    cmd_row_t    req;
    deq_result_t pred;
    deq_result_t want;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        req  = offered_requests.pop_front();
        pred = model_command(req.op, req.val);
        expected_results.push_back(req.pinned ? req.want : pred);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result request with nothing expected");
          error_total++;
        end else begin
          want = expected_results.pop_front();
          if (res_ch.pop_value !== want.pop_value) begin
            $error("pop_value: expected %0d, got %0d", want.pop_value, res_ch.pop_value);
            error_total++;
          end
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_ch.status);
            error_total++;
          end
          if (res_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   res_ch.entry_count);
            error_total++;
          end
        end
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.command    = CMD_PUSH_FRONT;
    cmd_ch.push_value = '0;
    shadow_front      = '0;
    shadow_count      = '0;
    error_total       = 0;
    plan_level        = 0;
    hold_off_req      = 1'b0;
    quiet_cycles      = 0;
    send_idle_pct     = 12;
    recv_idle_pct     = 69;

    directed_rows = '{
      // empty queue: pops fail, rotate does nothing
      '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{32'sd0, ST_EMPTY, 9'd0}},
      '{CMD_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{32'sd0, ST_EMPTY, 9'd0}},
      '{CMD_ROTATE,     32'h0000_0000, 1'b1, '{32'sd0, ST_OK,    9'd0}},
      '{CMD_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{32'sd0, ST_OK,    9'd1}},
      // single entry: rotate does nothing
      '{CMD_ROTATE,     32'hFFFF_FFFF, 1'b1, '{32'sd0, ST_OK,    9'd1}},
      '{CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'sd0, ST_OK,    9'd2}},
      '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, '{32'sd0, ST_OK,    9'd3}},
      '{CMD_PUSH_FRONT, 32'h0000_0000, 1'b1, '{32'sd0, ST_OK,    9'd4}},
      '{CMD_ROTATE,     32'h0000_0000, 1'b0, NO_RESULT},
      '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, NO_RESULT},
      '{CMD_POP_BACK,   32'h0000_0000, 1'b0, NO_RESULT},
      // ignored codes
      '{CMD_SPARE_A,    32'h5555_5555, 1'b1, '{32'sd0, ST_OK,    9'd2}},
      '{CMD_SPARE_B,    32'hAAAA_AAAA, 1'b1, '{32'sd0, ST_OK,    9'd2}},
      '{CMD_SPARE_C,    32'hFFFF_FFFF, 1'b1, '{32'sd0, ST_OK,    9'd2}},
      '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, NO_RESULT},
      '{CMD_POP_BACK,   32'h0000_0000, 1'b0, NO_RESULT},
      '{CMD_POP_BACK,   32'h0000_0000, 1'b1, '{32'sd0, ST_EMPTY, 9'd0}},
      // front pointer wraps below zero
      '{CMD_PUSH_FRONT, 32'h0000_0001, 1'b0, NO_RESULT},
      '{CMD_PUSH_FRONT, 32'h0000_0002, 1'b0, NO_RESULT},
      '{CMD_PUSH_FRONT, 32'h0000_0003, 1'b0, NO_RESULT},
      '{CMD_ROTATE,     32'h0000_0000, 1'b0, NO_RESULT},
      '{CMD_POP_BACK,   32'h0000_0000, 1'b0, NO_RESULT},
      '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, NO_RESULT},
      '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, NO_RESULT}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].val, directed_rows[i].pinned,
                   directed_rows[i].want);
    wait_for_results();

    // Slow receiver, with one long hold-off while the sender keeps going
    run_ops(MIX_OPS, 240, 60);
    wait_for_results();

    // Slow sender
    send_idle_pct = 69;
    recv_idle_pct = 12;
    run_ops(MIX_OPS, 240, -1);
    wait_for_results();

    // Full rate: fill to the top, push into a full queue, drain below empty
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (plan_level < DEPTH)
      send_request(pick_op(FILL_OPS), pick_value(), 1'b0, NO_RESULT);
    run_ops(FILL_OPS, 8, -1);
    while (plan_level > 0)
      send_request(pick_op(DRAIN_OPS), pick_value(), 1'b0, NO_RESULT);
    run_ops(DRAIN_OPS, 6, -1);
    wait_for_results();

    if (expected_results.size() != 0) begin
      $error("%0d result requests never arrived", expected_results.size());
      error_total++;
    end
    if (error_total == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue_with_half_rotate.f =====
+incdir+sv
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_store.sv
sv/double_ended_queue_with_half_rotate.sv
tb/tb_double_ended_queue_with_half_rotate.sv
